// ===== hdl/nsps_pkg.sv =====
`default_nettype none
package nsps_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  // three squares of at most 2^48 each fit in SQ_W bits
  localparam int DIST_W  = SQ_W;
  localparam int NIDX_W  = 10;

  // 100000 square metres in Q18.32
  localparam logic [DIST_W-1:0] DIST_LIMIT = DIST_W'(100000) << 32;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STS_CLEARED  = 3'd0,
    STS_STORED   = 3'd1,
    STS_FULL     = 3'd2,
    STS_ANSWERED = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage
`default_nettype wire

// ===== hdl/nsps_in_if.sv =====
`default_nettype none
interface nsps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           kind;
  logic signed [nsps_pkg::COORD_W-1:0]  pos_x;
  logic signed [nsps_pkg::COORD_W-1:0]  pos_y;
  logic signed [nsps_pkg::COORD_W-1:0]  pos_z;

  modport source (output valid, kind, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

// ===== hdl/nsps_out_if.sv =====
`default_nettype none
interface nsps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           status;
  logic signed [nsps_pkg::COORD_W-1:0]  near_x;
  logic signed [nsps_pkg::COORD_W-1:0]  near_y;
  logic signed [nsps_pkg::COORD_W-1:0]  near_z;
  logic [nsps_pkg::NIDX_W-1:0]          near_index;

  modport source (output valid, status, near_x, near_y, near_z, near_index, input ready);
  modport sink   (input valid, status, near_x, near_y, near_z, near_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/nsps_dist.sv =====
`default_nettype none
// Squared distance pipeline: abs difference, squares, sum. Three stages.
module nsps_dist #(
  parameter int IDX_W = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire [IDX_W-1:0]                  in_idx,
  input  wire nsps_pkg::point_t            query,
  input  wire nsps_pkg::point_t            point,
  output logic                             out_valid,
  output logic [IDX_W-1:0]                 out_idx,
  output logic [nsps_pkg::DIST_W-1:0]      out_dist,
  output logic                             busy
);

  logic signed [nsps_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [nsps_pkg::DIFF_W-1:0]        ax_r, ay_r, az_r;
  logic [nsps_pkg::SQ_W-1:0]          sx_r, sy_r, sz_r;
  logic                               ab_v_r, sq_v_r, sum_v_r;
  logic [IDX_W-1:0]                   ab_idx_r, sq_idx_r, sum_idx_r;
  logic [nsps_pkg::DIST_W-1:0]        sum_r;

  assign dx = nsps_pkg::DIFF_W'(query.x) - nsps_pkg::DIFF_W'(point.x);
  assign dy = nsps_pkg::DIFF_W'(query.y) - nsps_pkg::DIFF_W'(point.y);
  assign dz = nsps_pkg::DIFF_W'(query.z) - nsps_pkg::DIFF_W'(point.z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ab_v_r  <= 1'b0;
      sq_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
    end else begin
      ab_v_r  <= in_valid;
      sq_v_r  <= ab_v_r;
      sum_v_r <= sq_v_r;
    end
  end

  // magnitude of -2^24 reads correctly as unsigned
  always_ff @(posedge clk) begin
    ax_r      <= dx[nsps_pkg::DIFF_W-1] ? -dx : dx;
    ay_r      <= dy[nsps_pkg::DIFF_W-1] ? -dy : dy;
    az_r      <= dz[nsps_pkg::DIFF_W-1] ? -dz : dz;
    ab_idx_r  <= in_idx;
    sx_r      <= nsps_pkg::SQ_W'(ax_r) * nsps_pkg::SQ_W'(ax_r);
    sy_r      <= nsps_pkg::SQ_W'(ay_r) * nsps_pkg::SQ_W'(ay_r);
    sz_r      <= nsps_pkg::SQ_W'(az_r) * nsps_pkg::SQ_W'(az_r);
    sq_idx_r  <= ab_idx_r;
    sum_r     <= sx_r + sy_r + sz_r;
    sum_idx_r <= sq_idx_r;
  end

  assign out_valid = sum_v_r;
  assign out_idx   = sum_idx_r;
  assign out_dist  = sum_r;
  assign busy      = ab_v_r | sq_v_r | sum_v_r;

endmodule
`default_nettype wire

// ===== hdl/nearest_stored_point_search_top.sv =====
`default_nettype none
// Nearest stored point search. Points are appended into an on-chip store of
// MAX_POINTS entries (one synchronous RAM, one read and one write port); a
// query scans the stored points in order and returns the one at least squared
// distance, earliest on a tie, or point 0 if none lies under 100000 square
// metres. Clear, append and an empty-store query each have their result
// registered. A query on N stored points sweeps the single RAM read port
// one entry per cycle, followed by the distance pipeline drain and a
// re-read of the winning entry. One item is in work at a time. The store
// needs no clearing pass: the point count marks which entries are live.
module nearest_stored_point_search_top #(
  parameter int MAX_POINTS = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  nsps_in_if.sink      in_chan,
  nsps_out_if.source   out_chan
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_ANSWER
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [IDX_W-1:0]             scan_idx_r;
  logic                         rd_v_r;
  logic [IDX_W-1:0]             rd_idx_r;
  nsps_pkg::point_t             query_r;
  logic [nsps_pkg::DIST_W-1:0]  best_d_r;
  logic [IDX_W-1:0]             best_idx_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         out_load;
  nsps_pkg::status_t            out_status_r;
  nsps_pkg::point_t             out_point_r;
  logic [nsps_pkg::NIDX_W-1:0]  out_index_r;

  nsps_pkg::point_t             mem [MAX_POINTS];
  nsps_pkg::point_t             rd_data_r;
  logic [IDX_W-1:0]             rd_addr;
  logic                         wr_en;
  nsps_pkg::point_t             in_point;
  nsps_pkg::kind_t              in_kind;

  logic                         in_xfer, out_xfer;
  logic                         has_room, scan_last;
  logic                         dist_v, dist_busy;
  logic [IDX_W-1:0]             dist_idx;
  logic [nsps_pkg::DIST_W-1:0]  sq_dist;
  logic [31:0]                  best_idx_ext;

  assign in_point = '{x: in_chan.pos_x, y: in_chan.pos_y, z: in_chan.pos_z};
  assign in_kind  = nsps_pkg::kind_t'(in_chan.kind);

  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_xfer      = out_valid_r && out_chan.ready;

  assign has_room  = count_r < CNT_W'(MAX_POINTS);
  assign scan_last = CNT_W'(scan_idx_r) == (count_r - CNT_W'(1));
  assign wr_en     = in_xfer && (in_kind == nsps_pkg::KIND_APPEND) && has_room;
  assign rd_addr   = (state_r == ST_SCAN) ? scan_idx_r : best_idx_r;

  // a result is loaded on every item but the unused kind and a query that starts a scan, and in the answer state
  assign out_load      = (state_r == ST_ANSWER)
                         || (in_xfer && (in_kind != nsps_pkg::KIND_NONE)
                             && !((in_kind == nsps_pkg::KIND_QUERY) && (count_r != '0)));
  assign out_valid_nxt = out_load || (out_valid_r && !out_xfer);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_point;
    end
    rd_data_r <= mem[rd_addr];
  end

  nsps_dist #(.IDX_W(IDX_W)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_v_r),
    .in_idx    (rd_idx_r),
    .query     (query_r),
    .point     (rd_data_r),
    .out_valid (dist_v),
    .out_idx   (dist_idx),
    .out_dist  (sq_dist),
    .busy      (dist_busy)
  );

  assign best_idx_ext = 32'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= (state_r == ST_SCAN);
      rd_idx_r    <= scan_idx_r;

      // strict compare keeps the earliest point on a tie
      if (dist_v && (sq_dist < best_d_r)) begin
        best_d_r   <= sq_dist;
        best_idx_r <= dist_idx;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            out_point_r <= '0;
            out_index_r <= '0;
            unique case (in_kind)
              nsps_pkg::KIND_CLEAR: begin
                count_r      <= '0;
                out_status_r <= nsps_pkg::STS_CLEARED;
              end
              nsps_pkg::KIND_APPEND: begin
                if (has_room) begin
                  count_r      <= count_r + CNT_W'(1);
                  out_status_r <= nsps_pkg::STS_STORED;
                end else begin
                  out_status_r <= nsps_pkg::STS_FULL;
                end
              end
              nsps_pkg::KIND_QUERY: begin
                if (count_r == '0) begin
                  out_status_r <= nsps_pkg::STS_EMPTY;
                end else begin
                  query_r    <= in_point;
                  scan_idx_r <= '0;
                  best_d_r   <= nsps_pkg::DIST_LIMIT;
                  best_idx_r <= '0;
                  state_r    <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          scan_idx_r <= scan_idx_r + IDX_W'(1);
          if (scan_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_r && !dist_busy) begin
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_r <= ST_ANSWER;
        end
        ST_ANSWER: begin
          out_status_r <= nsps_pkg::STS_ANSWERED;
          out_point_r  <= rd_data_r;
          out_index_r  <= best_idx_ext[nsps_pkg::NIDX_W-1:0];
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.near_x     = out_point_r.x;
  assign out_chan.near_y     = out_point_r.y;
  assign out_chan.near_z     = out_point_r.z;
  assign out_chan.near_index = out_index_r;

endmodule
`default_nettype wire
